/* src/xsk_pkg.sv */
package xsk_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] state_t;
  typedef word_t [7:0]  subkey_t;
  typedef logic [2:0]   pos_t;

  localparam word_t SIGMA0 = 32'h61707865;
  localparam word_t SIGMA1 = 32'h3320646e;
  localparam word_t SIGMA2 = 32'h79622d32;
  localparam word_t SIGMA3 = 32'h6b206574;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_NONCE0  = 3'd4,
    REG_NONCE1  = 3'd5,
    REG_NONCE2  = 3'd6,
    REG_KS_ONLY = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_SUBKEY,
    ENG_BLOCK,
    ENG_ADD
  } eng_state_t;

  // One queued item with its place in the message already worked out.
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    pos_t        pos;
    logic        start;
  } item_t;

  typedef struct packed {
    logic start_sub;
    logic start_blk;
    logic abort;
  } eng_cmd_t;

  typedef struct packed {
    logic busy;
    logic sub_done;
    logic blk_done;
  } eng_sts_t;

  function automatic word_t rotl(word_t v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Returns {a, b, c, d} after one quarter round.
  function automatic logic [127:0] quarter(word_t a, word_t b, word_t c, word_t d);
    word_t a2;
    word_t b2;
    word_t c2;
    word_t d2;
    b2 = b ^ rotl(a + d, 7);
    c2 = c ^ rotl(b2 + a, 9);
    d2 = d ^ rotl(c2 + b2, 13);
    a2 = a ^ rotl(d2 + c2, 18);
    return {a2, b2, c2, d2};
  endfunction

  function automatic state_t col_round(state_t x);
    state_t y;
    y = x;
    {y[0],  y[4],  y[8],  y[12]} = quarter(x[0],  x[4],  x[8],  x[12]);
    {y[5],  y[9],  y[13], y[1]}  = quarter(x[5],  x[9],  x[13], x[1]);
    {y[10], y[14], y[2],  y[6]}  = quarter(x[10], x[14], x[2],  x[6]);
    {y[15], y[3],  y[7],  y[11]} = quarter(x[15], x[3],  x[7],  x[11]);
    return y;
  endfunction

  function automatic state_t row_round(state_t x);
    state_t y;
    y = x;
    {y[0],  y[1],  y[2],  y[3]}  = quarter(x[0],  x[1],  x[2],  x[3]);
    {y[5],  y[6],  y[7],  y[4]}  = quarter(x[5],  x[6],  x[7],  x[4]);
    {y[10], y[11], y[8],  y[9]}  = quarter(x[10], x[11], x[8],  x[9]);
    {y[15], y[12], y[13], y[14]} = quarter(x[15], x[12], x[13], x[14]);
    return y;
  endfunction

  // Even rounds are column rounds, odd rounds are row rounds.
  function automatic state_t salsa_round(state_t x, logic odd);
    return odd ? row_round(x) : col_round(x);
  endfunction

endpackage

/* src/xsk_queue.sv */
module xsk_queue import xsk_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  head_valid
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  item_t            mem_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r;
  logic [AW-1:0]    rd_ptr_nxt;
  logic [AW:0]      count_r;
  logic [AW:0]      count_nxt;

  assign full       = count_r == (AW+1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* src/xsk_front.sv */
module xsk_front import xsk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data,
  input  logic [3:0]  in_count,
  input  logic        in_last,
  input  logic        q_full,
  output logic        push,
  output item_t       push_item
);

  logic start_r;
  logic start_nxt;
  pos_t pos_r;
  pos_t pos_nxt;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.data  = in_data;
    push_item.count = in_count;
    push_item.last  = in_last;
    push_item.pos   = pos_r;
    push_item.start = start_r;
    start_nxt = start_r;
    pos_nxt   = pos_r;
    if (push) begin
      // A last beat closes the message; the next beat opens a new one.
      start_nxt = in_last;
      pos_nxt   = in_last ? '0 : pos_r + pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 1'b1;
      pos_r   <= '0;
    end else begin
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

/* src/xsk_core.sv */
module xsk_core import xsk_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  eng_cmd_t     cmd,
  input  logic [255:0] key,
  input  logic [127:0] hnonce,
  input  logic [63:0]  bnonce,
  input  logic [63:0]  ctr,
  output eng_sts_t     sts,
  output state_t       blk
);

  localparam int unsigned RW = $clog2(ROUND_COUNT);

  eng_state_t    st_r;
  eng_state_t    st_nxt;
  logic [RW-1:0] rnd_r;
  logic [RW-1:0] rnd_nxt;
  state_t        x_r;
  state_t        x_nxt;
  state_t        init_r;
  state_t        init_nxt;
  subkey_t       sk_r;
  subkey_t       sk_nxt;
  state_t        hs_init;
  state_t        blk_init;
  state_t        rnd_out;
  state_t        sum;
  logic          last_rnd;

  assign blk = x_r;

  always_comb begin
    hs_init[0]  = SIGMA0;
    hs_init[5]  = SIGMA1;
    hs_init[10] = SIGMA2;
    hs_init[15] = SIGMA3;
    hs_init[1]  = key[31:0];
    hs_init[2]  = key[63:32];
    hs_init[3]  = key[95:64];
    hs_init[4]  = key[127:96];
    hs_init[11] = key[159:128];
    hs_init[12] = key[191:160];
    hs_init[13] = key[223:192];
    hs_init[14] = key[255:224];
    hs_init[6]  = hnonce[31:0];
    hs_init[7]  = hnonce[63:32];
    hs_init[8]  = hnonce[95:64];
    hs_init[9]  = hnonce[127:96];

    blk_init[0]  = SIGMA0;
    blk_init[5]  = SIGMA1;
    blk_init[10] = SIGMA2;
    blk_init[15] = SIGMA3;
    blk_init[1]  = sk_r[0];
    blk_init[2]  = sk_r[1];
    blk_init[3]  = sk_r[2];
    blk_init[4]  = sk_r[3];
    blk_init[11] = sk_r[4];
    blk_init[12] = sk_r[5];
    blk_init[13] = sk_r[6];
    blk_init[14] = sk_r[7];
    blk_init[6]  = bnonce[31:0];
    blk_init[7]  = bnonce[63:32];
    blk_init[8]  = ctr[31:0];
    blk_init[9]  = ctr[63:32];
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sum[i] = x_r[i] + init_r[i];
    end
  end

  assign rnd_out  = salsa_round(x_r, rnd_r[0]);
  assign last_rnd = rnd_r == RW'(ROUND_COUNT - 1);

  always_comb begin
    st_nxt   = st_r;
    rnd_nxt  = rnd_r;
    x_nxt    = x_r;
    init_nxt = init_r;
    sk_nxt   = sk_r;
    sts      = '0;
    sts.busy = st_r != ENG_IDLE;
    unique case (st_r)
      ENG_IDLE: begin
        if (cmd.abort) begin
          st_nxt = ENG_IDLE;
        end else if (cmd.start_sub) begin
          x_nxt   = hs_init;
          rnd_nxt = '0;
          st_nxt  = ENG_SUBKEY;
        end else if (cmd.start_blk) begin
          x_nxt    = blk_init;
          init_nxt = blk_init;
          rnd_nxt  = '0;
          st_nxt   = ENG_BLOCK;
        end
      end
      ENG_SUBKEY: begin
        x_nxt   = rnd_out;
        rnd_nxt = rnd_r + RW'(1);
        if (last_rnd) begin
          sk_nxt       = {rnd_out[9], rnd_out[8], rnd_out[7], rnd_out[6],
                          rnd_out[15], rnd_out[10], rnd_out[5], rnd_out[0]};
          st_nxt       = ENG_IDLE;
          sts.sub_done = 1'b1;
        end
      end
      ENG_BLOCK: begin
        if (cmd.abort) begin
          st_nxt = ENG_IDLE;
        end else begin
          x_nxt   = rnd_out;
          rnd_nxt = rnd_r + RW'(1);
          if (last_rnd) begin
            st_nxt = ENG_ADD;
          end
        end
      end
      ENG_ADD: begin
        st_nxt = ENG_IDLE;
        if (!cmd.abort) begin
          x_nxt        = sum;
          sts.blk_done = 1'b1;
        end
      end
      default: begin
        st_nxt = ENG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ENG_IDLE;
      rnd_r <= '0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    init_r <= init_nxt;
    sk_r   <= sk_nxt;
  end

endmodule

/* src/xsk_back.sv */
module xsk_back import xsk_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic         clk,
  input  logic         rst_n,
  input  item_t        head,
  input  logic         head_valid,
  output logic         pop,
  input  logic [255:0] key,
  input  logic [127:0] hnonce,
  input  logic [63:0]  bnonce,
  input  logic         ks_only,
  input  logic         nonce_wr,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [63:0]  out_data,
  output logic [3:0]   out_count,
  output logic         out_last
);

  eng_cmd_t    cmd;
  eng_sts_t    sts;
  state_t      blk;
  logic [63:0] core_ctr;

  logic        sk_ok_r;
  logic        sk_ok_nxt;
  logic        pre_valid_r;
  logic        pre_valid_nxt;
  logic [63:0] ctr_r;
  logic [63:0] ctr_nxt;
  logic [63:0] ctr_inc;
  state_t      kb_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] data_r;
  logic [3:0]  count_r;
  logic        last_r;

  logic        pos0;
  logic        slot_free;
  logic        item_ready;
  logic        fire;
  logic        fire_new_blk;
  logic        fire_last;
  logic [63:0] ks;
  logic [63:0] mask;
  logic [63:0] res;

  xsk_core #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .key    (key),
    .hnonce (hnonce),
    .bnonce (bnonce),
    .ctr    (core_ctr),
    .sts    (sts),
    .blk    (blk)
  );

  assign pos0       = head.pos == '0;
  assign slot_free  = !out_valid_r || !out_stall;
  assign item_ready = (!head.start || sk_ok_r) && (!pos0 || pre_valid_r);
  assign fire       = head_valid && slot_free && item_ready;
  assign fire_new_blk = fire && pos0;
  assign fire_last    = fire && head.last;
  assign pop        = fire;
  assign ctr_inc    = ctr_r + 64'd1;
  // The next block can start in the same cycle the finished one moves over.
  assign core_ctr   = fire_new_blk ? ctr_inc : ctr_r;

  always_comb begin
    cmd.abort     = nonce_wr || fire_last;
    cmd.start_sub = head_valid && head.start && !sk_ok_r && !sts.busy;
    cmd.start_blk = sk_ok_r && !sts.busy && (!pre_valid_r || fire_new_blk);
  end

  always_comb begin
    if (pos0) begin
      ks = {blk[1], blk[0]};
    end else begin
      ks = {kb_r[{head.pos, 1'b1}], kb_r[{head.pos, 1'b0}]};
    end
    for (int k = 0; k < 8; k++) begin
      mask[8*k +: 8] = {8{4'(k) < head.count}};
    end
    res = (ks_only ? ks : (head.data ^ ks)) & mask;
  end

  always_comb begin
    sk_ok_nxt = sk_ok_r;
    if (fire_last) begin
      sk_ok_nxt = 1'b0;
    end else if (sts.sub_done) begin
      sk_ok_nxt = 1'b1;
    end

    pre_valid_nxt = pre_valid_r;
    if (cmd.abort) begin
      pre_valid_nxt = 1'b0;
    end else if (sts.blk_done) begin
      pre_valid_nxt = 1'b1;
    end else if (fire_new_blk) begin
      pre_valid_nxt = 1'b0;
    end

    ctr_nxt = ctr_r;
    if (sts.sub_done) begin
      ctr_nxt = '0;
    end else if (fire_new_blk) begin
      ctr_nxt = ctr_inc;
    end

    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sk_ok_r     <= 1'b0;
      pre_valid_r <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sk_ok_r     <= sk_ok_nxt;
      pre_valid_r <= pre_valid_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_new_blk) begin
      kb_r <= blk;
    end
    if (fire) begin
      data_r  <= res;
      count_r <= head.count;
      last_r  <= head.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = data_r;
  assign out_count = count_r;
  assign out_last  = last_r;

endmodule

/* src/xsalsa20_keystream_xor_top.sv */
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  data_in 64, byte_count 4, last_in 1
// out_      output     out_valid / out_stall data_out 64, byte_count_out 4, last_out 1
// cfg_      input      cfg_valid / cfg_ready index 3, data 64
//
// Each 64-byte keystream block is made by the round engine (load, one Salsa20
// round per cycle, final add) and serves eight beats. The first beat of a
// message also waits for the HSalsa20 subkey. Reset is synchronous and active
// low; there is no clearing pass. A stall on the result side fills the
// four-entry queue and only then raises in_stall.
module xsalsa20_keystream_xor_top import xsk_pkg::*; #(
  parameter int unsigned ROUND_COUNT = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_in,
  input  logic [3:0]  in_byte_count,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data_out,
  output logic [3:0]  out_byte_count_out,
  output logic        out_last_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  // Configuration registers. The subkey is taken from the key and the first
  // sixteen nonce bytes when a message starts, so later writes to those only
  // affect the next message. The block nonce is read each time a block is
  // made, and keystream-only is read at every beat.
  logic [63:0] key_r [4];
  logic [63:0] nonce_r [3];
  logic        ks_only_r;
  logic        nonce_wr;
  logic        cfg_we;

  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        pop;
  item_t       head;
  logic        head_valid;

  // Writes are always taken at once.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  // A new block nonce makes any block the engine has run ahead on stale.
  assign nonce_wr  = cfg_we && (reg_idx_t'(cfg_index) == REG_NONCE2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        nonce_r[i] <= '0;
      end
      ks_only_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY0:    key_r[0]   <= cfg_data;
        REG_KEY1:    key_r[1]   <= cfg_data;
        REG_KEY2:    key_r[2]   <= cfg_data;
        REG_KEY3:    key_r[3]   <= cfg_data;
        REG_NONCE0:  nonce_r[0] <= cfg_data;
        REG_NONCE1:  nonce_r[1] <= cfg_data;
        REG_NONCE2:  nonce_r[2] <= cfg_data;
        REG_KS_ONLY: ks_only_r  <= cfg_data[0];
        default:     ks_only_r  <= ks_only_r;
      endcase
    end
  end

  // The front end tags every beat with its word position in the current block
  // and whether it opens a message, then hands it to the queue.
  xsk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data_in),
    .in_count  (in_byte_count),
    .in_last   (in_last_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  xsk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // The back end owns the round engine. It builds the subkey for a beat that
  // opens a message, keeps the current block for the beats that follow, and
  // computes the next block ahead while those beats drain.
  xsk_back #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .key        ({key_r[3], key_r[2], key_r[1], key_r[0]}),
    .hnonce     ({nonce_r[1], nonce_r[0]}),
    .bnonce     (nonce_r[2]),
    .ks_only    (ks_only_r),
    .nonce_wr   (nonce_wr),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data_out),
    .out_count  (out_byte_count_out),
    .out_last   (out_last_out)
  );

endmodule
